// ===== src/rpc_pkg.sv =====
// Shared constants, types and interface structs of the rook placement counter.
`default_nettype none

package rpc_pkg;

   localparam int TABLE_DIM = 32;
   localparam int MAX_SIDE  = TABLE_DIM - 1;
   localparam int ROW_AW    = (TABLE_DIM > 1) ? $clog2(TABLE_DIM) : 1;
   localparam int SIDE_W    = 5;
   localparam int COUNT_W   = 10;
   localparam int WAYS_W    = 64;
   localparam int HALF_W    = WAYS_W / 2;

   typedef logic [ROW_AW-1:0] row_idx_type;
   typedef logic [WAYS_W-1:0] ways_type;
   typedef logic [HALF_W-1:0] half_type;

   typedef struct packed {
      logic        en;
      row_idx_type addr;
      ways_type    data;
   } row_wr_type;

   typedef struct packed {
      logic        start;
      row_idx_type side;
      row_idx_type pick;
   } binom_req_type;

   typedef struct packed {
      logic     done;
      ways_type coef;
   } binom_rsp_type;

   typedef struct packed {
      logic     start;
      ways_type a;
      ways_type b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      ways_type product;
   } mul_rsp_type;

endpackage

`default_nettype wire

// ===== src/rpc_row_mem.sv =====
// Pascal row store: one write port and one registered read port.
`default_nettype none

module rpc_row_mem (
   input  wire logic                clock,
   input  wire rpc_pkg::row_wr_type wr,
   input  wire rpc_pkg::row_idx_type rd_addr,
   output rpc_pkg::ways_type        rd_data
);

   rpc_pkg::ways_type mem [rpc_pkg::TABLE_DIM];
   rpc_pkg::ways_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/rpc_binom.sv =====
// Pascal row sequencer that builds C(n,k) in the row store, one addition a cycle within each row.
`default_nettype none

module rpc_binom (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire rpc_pkg::binom_req_type req,
   output rpc_pkg::binom_rsp_type     rsp
);

   typedef enum logic [2:0] {
      IDLE,
      INIT,
      ROW,
      STEP,
      FETCH,
      WAIT
   } state_type;

   state_type            state_ff;
   rpc_pkg::row_idx_type m_ff;
   rpc_pkg::row_idx_type j_ff;
   rpc_pkg::row_idx_type side_ff;
   rpc_pkg::row_idx_type pick_ff;
   rpc_pkg::ways_type    prev_ff;
   rpc_pkg::ways_type    coef_ff;
   logic                 done_ff;

   rpc_pkg::row_wr_type  wr;
   rpc_pkg::row_idx_type rd_addr;
   rpc_pkg::ways_type    rd_data;

   rpc_row_mem u_row_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr.en   = (state_ff == INIT) || (state_ff == STEP);
      wr.addr = (state_ff == INIT) ? '0 : j_ff;
      wr.data = (state_ff == INIT) ? rpc_pkg::ways_type'(1) : prev_ff + rd_data;
      case (state_ff)
         ROW:     rd_addr = j_ff - rpc_pkg::row_idx_type'(1);
         STEP:    rd_addr = j_ff - rpc_pkg::row_idx_type'(2);
         FETCH:   rd_addr = pick_ff;
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == WAIT);
         case (state_ff)
            IDLE: begin
               if (req.start) begin
                  side_ff  <= req.side;
                  pick_ff  <= req.pick;
                  state_ff <= INIT;
               end
            end
            INIT: begin
               m_ff     <= rpc_pkg::row_idx_type'(1);
               j_ff     <= rpc_pkg::row_idx_type'(1);
               state_ff <= (side_ff == '0) ? FETCH : ROW;
            end
            ROW: begin
               prev_ff  <= '0;
               state_ff <= STEP;
            end
            STEP: begin
               prev_ff <= rd_data;
               if (j_ff == rpc_pkg::row_idx_type'(1)) begin
                  if (m_ff == side_ff) begin
                     state_ff <= FETCH;
                  end else begin
                     m_ff     <= m_ff + rpc_pkg::row_idx_type'(1);
                     j_ff     <= m_ff + rpc_pkg::row_idx_type'(1);
                     state_ff <= ROW;
                  end
               end else begin
                  j_ff <= j_ff - rpc_pkg::row_idx_type'(1);
               end
            end
            FETCH: begin
               state_ff <= WAIT;
            end
            WAIT: begin
               coef_ff  <= rd_data;
               state_ff <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.coef = coef_ff;

endmodule

`default_nettype wire

// ===== src/rpc_mul.sv =====
// Wrapping 64 by 64 multiplier built from three 32 by 32 partial products.
`default_nettype none

module rpc_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rpc_pkg::mul_req_type req,
   output rpc_pkg::mul_rsp_type     rsp
);

   typedef enum logic {
      IDLE,
      BUSY
   } state_type;

   state_type         state_ff;
   logic [1:0]        step_ff;
   logic              shift_ff;
   logic              done_ff;
   rpc_pkg::ways_type a_ff;
   rpc_pkg::ways_type b_ff;
   rpc_pkg::ways_type pp_ff;
   rpc_pkg::ways_type acc_ff;

   rpc_pkg::half_type a_sel;
   rpc_pkg::half_type b_sel;
   rpc_pkg::ways_type pp_in;
   rpc_pkg::ways_type acc_in;

   always_comb begin
      case (step_ff)
         2'd1: begin
            a_sel = a_ff[rpc_pkg::HALF_W-1:0];
            b_sel = b_ff[rpc_pkg::WAYS_W-1:rpc_pkg::HALF_W];
         end
         2'd2: begin
            a_sel = a_ff[rpc_pkg::WAYS_W-1:rpc_pkg::HALF_W];
            b_sel = b_ff[rpc_pkg::HALF_W-1:0];
         end
         default: begin
            a_sel = a_ff[rpc_pkg::HALF_W-1:0];
            b_sel = b_ff[rpc_pkg::HALF_W-1:0];
         end
      endcase
      pp_in  = {rpc_pkg::half_type'(0), a_sel} * {rpc_pkg::half_type'(0), b_sel};
      acc_in = acc_ff + (shift_ff ? {pp_ff[rpc_pkg::HALF_W-1:0], rpc_pkg::half_type'(0)}
                                  : pp_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff  <= 1'b0;
         step_ff  <= 2'd0;
      end else begin
         done_ff <= (state_ff == BUSY) && (step_ff == 2'd3);
         case (state_ff)
            IDLE: begin
               if (req.start) begin
                  a_ff     <= req.a;
                  b_ff     <= req.b;
                  acc_ff   <= '0;
                  step_ff  <= 2'd0;
                  state_ff <= BUSY;
               end
            end
            BUSY: begin
               if (step_ff != 2'd3) begin
                  pp_ff    <= pp_in;
                  shift_ff <= (step_ff != 2'd0);
               end
               if (step_ff != 2'd0) begin
                  acc_ff <= acc_in;
               end
               if (step_ff == 2'd3) begin
                  state_ff <= IDLE;
               end
               step_ff <= step_ff + 2'd1;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp.done    = done_ff;
   assign rsp.product = acc_ff;

endmodule

`default_nettype wire

// ===== src/rook_placement_counter.sv =====
// Top level of the rook placement counter: item control, product chain and result register.
//
//   Channel | Direction | Ports                                   | Word
//   req     | in        | req_valid, req_stall, req_board_side,   | board side n, rook count k
//           |           | req_rook_count                          |
//   rsp     | out       | rsp_valid, rsp_stall, rsp_ways          | placement count mod 2^64
//
// For 1 <= k <= n, the item first runs the Pascal sweep, which does one addition a cycle
// within each row, and then the chain of k products before its word is loaded.
// Items with k = 0 or k > n skip the sweep and the products and go straight to the output state.
// The input stalls until the word is in the output register; that wait grows while an
// earlier word is stalled there. The next word may be taken one cycle after the result loads.
// Reset is synchronous and clears all control state; the row store needs no clearing.
`default_nettype none

module rook_placement_counter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rpc_pkg::SIDE_W-1:0]    req_board_side,
   input  wire logic [rpc_pkg::COUNT_W-1:0]   req_rook_count,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [rpc_pkg::WAYS_W-1:0]         rsp_ways
);

   typedef enum logic [1:0] {
      IDLE,
      BINOM,
      MUL,
      OUT
   } state_type;

   state_type              state_ff;
   rpc_pkg::row_idx_type   k_ff;
   rpc_pkg::row_idx_type   cnt_ff;
   rpc_pkg::ways_type      res_ff;
   rpc_pkg::ways_type      mul_b_ff;
   logic                   mul_start_ff;
   logic                   binom_start_ff;
   rpc_pkg::row_idx_type   side_ff;
   logic                   rsp_valid_ff;
   rpc_pkg::ways_type      rsp_ways_ff;

   rpc_pkg::row_idx_type   side_sat;
   logic                   too_many;
   logic                   accept;

   rpc_pkg::binom_req_type binom_req;
   rpc_pkg::binom_rsp_type binom_rsp;
   rpc_pkg::mul_req_type   mul_req;
   rpc_pkg::mul_rsp_type   mul_rsp;

   always_comb begin
      if (32'(req_board_side) > rpc_pkg::MAX_SIDE) begin
         side_sat = rpc_pkg::row_idx_type'(rpc_pkg::MAX_SIDE);
      end else begin
         side_sat = rpc_pkg::row_idx_type'(req_board_side);
      end
      too_many = 32'(req_rook_count) > 32'(side_sat);
   end

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;

   assign binom_req.start = binom_start_ff;
   assign binom_req.side  = side_ff;
   assign binom_req.pick  = k_ff;

   assign mul_req.start = mul_start_ff;
   assign mul_req.a     = res_ff;
   assign mul_req.b     = mul_b_ff;

   rpc_binom u_binom (
      .clock (clock),
      .reset (reset),
      .req   (binom_req),
      .rsp   (binom_rsp)
   );

   rpc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= IDLE;
         mul_start_ff   <= 1'b0;
         binom_start_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         binom_start_ff <= accept && !too_many && (req_rook_count != '0);
         mul_start_ff   <= ((state_ff == BINOM) && binom_rsp.done)
                        || ((state_ff == MUL) && mul_rsp.done && (cnt_ff != k_ff));
         if (rsp_valid_ff && !rsp_stall && (state_ff != OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (accept) begin
                  side_ff <= side_sat;
                  k_ff    <= rpc_pkg::row_idx_type'(req_rook_count);
                  if (too_many) begin
                     res_ff   <= '0;
                     state_ff <= OUT;
                  end else if (req_rook_count == '0) begin
                     res_ff   <= rpc_pkg::ways_type'(1);
                     state_ff <= OUT;
                  end else begin
                     state_ff <= BINOM;
                  end
               end
            end
            BINOM: begin
               if (binom_rsp.done) begin
                  res_ff   <= binom_rsp.coef;
                  mul_b_ff <= binom_rsp.coef;
                  cnt_ff   <= rpc_pkg::row_idx_type'(1);
                  state_ff <= MUL;
               end
            end
            MUL: begin
               if (mul_rsp.done) begin
                  res_ff <= mul_rsp.product;
                  if (cnt_ff == k_ff) begin
                     state_ff <= OUT;
                  end else begin
                     cnt_ff   <= cnt_ff + rpc_pkg::row_idx_type'(1);
                     mul_b_ff <= rpc_pkg::ways_type'(cnt_ff + rpc_pkg::row_idx_type'(1));
                  end
               end
            end
            OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ways_ff  <= res_ff;
                  state_ff     <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ways  = rsp_ways_ff;

endmodule

`default_nettype wire
